/* rtl/core/smpq_pkg.sv */
// shared types and constants for the sorted minimum priority queue
package smpq_pkg;

    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 5;
    localparam int DEF_CAPACITY = 16;

    typedef enum logic
    {
        CMD_INSERT  = 1'b0,
        CMD_EXTRACT = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = '1;

    // data handed from one cell to its neighbor
    typedef struct packed
    {
        logic              gt;
        logic [DATA_W-1:0] value;
    } smpq_link_t;

    // operation broadcast to every cell
    typedef struct packed
    {
        logic              ins;
        logic              ext;
        logic [DATA_W-1:0] item;
    } smpq_ctl_t;

    // where a cell sits relative to the fill level
    typedef struct packed
    {
        logic occupied;
        logic tail;
    } smpq_pos_t;

endpackage

/* rtl/core/smpq_if.sv */
// request and response channel interfaces
interface smpq_req_if;
    import smpq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, output cmd, output item_value, input ready);
    modport sink   (input valid, input cmd, input item_value, output ready);
endinterface

interface smpq_rsp_if;
    import smpq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] min_value;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output status, output min_value, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input min_value, input occupancy,
                    output ready);
endinterface

/* rtl/core/smpq_cell.sv */
// one storage cell of the sorted shift chain
module smpq_cell
(
    input  logic                        clk,
    input  smpq_pkg::smpq_ctl_t         ctl,
    input  smpq_pkg::smpq_pos_t         pos,
    input  smpq_pkg::smpq_link_t        left,
    input  logic [smpq_pkg::DATA_W-1:0] right_value,
    output smpq_pkg::smpq_link_t        link
);
    import smpq_pkg::*;

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              gt_here;

    assign gt_here    = pos.occupied && ($signed(value_reg) > $signed(ctl.item));
    assign link.gt    = gt_here;
    assign link.value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.ins)
        begin
            // left neighbor pushes right; first larger slot, else the tail slot, takes the new item
            if (left.gt)
            begin
                value_next = left.value;
            end
            else if (gt_here || pos.tail)
            begin
                value_next = ctl.item;
            end
        end
        else if (ctl.ext)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

/* rtl/core/sorted_min_priority_queue.sv */
// top level of the sorted minimum priority queue
//
//  channel  dir  payload                          transfer
//  req      in   cmd, item_value                  valid & ready
//  rsp      out  status, min_value, occupancy     valid & ready
//
// one request per cycle unless a waiting response holds req.ready low: every cell compares and shifts in the same cycle
// the response is registered and appears in the output register in the cycle after the transfer
// req.ready is low only while a response waits and rsp.ready is low
// reset empties the queue; stored values are not cleared
module sorted_min_priority_queue
#(
    parameter int CAPACITY = smpq_pkg::DEF_CAPACITY
)
(
    input  logic        clk,
    input  logic        rst_n,
    smpq_req_if.sink    req,
    smpq_rsp_if.source  rsp
);
    import smpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [DATA_W-1:0] min_reg;
    logic [DATA_W-1:0] min_next;
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;

    logic              accept;
    logic              full;
    logic              empty;
    smpq_ctl_t         ctl;
    smpq_link_t        link [CAPACITY];

    assign accept    = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    assign ctl.ins  = accept && (req.cmd == CMD_INSERT) && !full;
    assign ctl.ext  = accept && (req.cmd == CMD_EXTRACT) && !empty;
    assign ctl.item = req.item_value;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            smpq_pos_t         pos;
            smpq_link_t        left;
            logic [DATA_W-1:0] right_value;

            assign pos.occupied = CNT_W'(i) < count_reg;
            assign pos.tail     = CNT_W'(i) == count_reg;

            if (i == 0)
            begin : g_head
                assign left = '0;
            end
            else
            begin : g_body
                assign left = link[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_value = '0;
            end
            else
            begin : g_inner
                assign right_value = link[i+1].value;
            end

            smpq_cell u_cell
            (
                .clk         (clk),
                .ctl         (ctl),
                .pos         (pos),
                .left        (left),
                .right_value (right_value),
                .link        (link[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        min_next       = min_reg;
        occ_next       = occ_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            status_next    = ST_OK;
            min_next       = '0;
            if (ctl.ins)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (ctl.ext)
            begin
                count_next = count_reg - 1'b1;
                min_next   = link[0].value;
            end
            else if (req.cmd == CMD_INSERT)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_EMPTY;
                min_next    = EMPTY_VALUE;
            end
            occ_next = OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        min_reg    <= min_next;
        occ_reg    <= occ_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.min_value = min_reg;
    assign rsp.occupancy = occ_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill level above capacity");

    a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the queue");

    a_full_drop : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == CMD_INSERT) && full) |=>
            (status_reg == ST_FULL) && (count_reg == CNT_W'(CAPACITY)))
        else $error("insert into full queue changed state");

    a_empty_value : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg == ST_EMPTY)) |->
            ((min_reg == EMPTY_VALUE) && (occ_reg == '0)))
        else $error("empty response malformed");

endmodule
